// File: src/psat_pkg.sv
// psat_pkg: shared types, constants and codes for the polygon separating-axis block
// no dependencies
`default_nettype none
package psat_pkg;
    localparam int MAX_VERTS_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // item kinds
    localparam logic [1:0] KIND_VERT_ONE = 2'd0;
    localparam logic [1:0] KIND_VERT_TWO = 2'd1;
    localparam logic [1:0] KIND_POS_ONE  = 2'd2;
    localparam logic [1:0] KIND_POS_TWO  = 2'd3;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_COUNT = 1'b1;

    localparam int UNIT_SHIFT = 14;

    // result beat
    typedef struct packed {
        logic               hit;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [30:0] depth;
        logic               status;
    } result_t;
endpackage
`default_nettype wire

// File: src/polygon_sat_collision_top.sv
// polygon_sat_collision_top: queue-style wrapper over front loader and back test engine
// depends on psat_pkg, psat_front, psat_back
`default_nettype none
// Vertices and positions load one beat per cycle while full is low; a beat with
// last set starts a separating-axis test in the next cycle, and full stays high
// until the test has registered its result. A result waiting to be popped does
// not block new loads; the following test then holds in its final state until
// that result is popped. Each edge runs two vertex reads, a scale step plus one
// per halving, squares, a 32-step square root, a restoring divide of both
// components and the compare, plus a projection step per vertex of both bodies;
// a zero-length edge goes from the scale step straight to the compare. A bad
// vertex count goes straight from idle to the result.
module polygon_sat_collision_top #(
    parameter int MAX_VERTS   = psat_pkg::MAX_VERTS_DEF,
    parameter int COORD_WIDTH = psat_pkg::COORD_WIDTH_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    output logic               full,
    input  wire  [1:0]         kind,
    input  wire  signed [31:0] coord_x,
    input  wire  signed [31:0] coord_y,
    input  wire                last,
    output logic               empty,
    input  wire                pop,
    output logic               hit,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [30:0]        depth,
    output logic               status
);
    localparam int CNT_W = $clog2(MAX_VERTS + 2);
    localparam int IDX_W = $clog2(MAX_VERTS);

    logic start, busy, rv;
    logic [CNT_W-1:0] c1, c2;
    logic signed [32:0] dx, dy;
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic [IDX_W-1:0] ri;
    psat_pkg::result_t r;

    psat_front #(.MAX_VERTS(MAX_VERTS), .COORD_WIDTH(COORD_WIDTH),
                 .CNT_W(CNT_W), .IDX_W(IDX_W)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .coord_x(coord_x), .coord_y(coord_y), .last(last), .start(start),
        .busy(busy), .cnt_one(c1), .cnt_two(c2), .pos_dx(dx), .pos_dy(dy),
        .rd_idx(ri), .v1x(v1x), .v1y(v1y), .v2x(v2x), .v2y(v2y));

    psat_back #(.MAX_VERTS(MAX_VERTS), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_back (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cnt_one(c1),
        .cnt_two(c2), .pos_dx(dx), .pos_dy(dy), .rd_idx(ri), .v1x(v1x),
        .v1y(v1y), .v2x(v2x), .v2y(v2y), .res_valid(rv), .res(r),
        .res_ready(pop));

    assign empty    = ~rv;
    assign hit      = r.hit;
    assign normal_x = r.normal_x;
    assign normal_y = r.normal_y;
    assign depth    = r.depth;
    assign status   = r.status;
endmodule
`default_nettype wire

// File: src/psat_front.sv
// psat_front: accepts input beats, stores vertices and positions, issues test commands
// depends on psat_pkg
`default_nettype none
module psat_front #(
    parameter int MAX_VERTS   = psat_pkg::MAX_VERTS_DEF,
    parameter int COORD_WIDTH = psat_pkg::COORD_WIDTH_DEF,
    parameter int CNT_W       = $clog2(MAX_VERTS + 2),
    parameter int IDX_W       = $clog2(MAX_VERTS)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    output logic                    full,
    input  wire  [1:0]              kind,
    input  wire  signed [31:0]      coord_x,
    input  wire  signed [31:0]      coord_y,
    input  wire                     last,
    // test start handshake to the back part
    output logic                    start,
    input  wire                     busy,
    output logic [CNT_W-1:0]        cnt_one,
    output logic [CNT_W-1:0]        cnt_two,
    output logic signed [32:0]      pos_dx,
    output logic signed [32:0]      pos_dy,
    input  wire  [IDX_W-1:0]        rd_idx,
    output logic signed [31:0]      v1x,
    output logic signed [31:0]      v1y,
    output logic signed [31:0]      v2x,
    output logic signed [31:0]      v2y
);
    localparam int CWE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    logic signed [31:0] vx1_mem [MAX_VERTS];
    logic signed [31:0] vy1_mem [MAX_VERTS];
    logic signed [31:0] vx2_mem [MAX_VERTS];
    logic signed [31:0] vy2_mem [MAX_VERTS];
    logic [CNT_W-1:0]   cnt_one_reg, cnt_two_reg;
    logic signed [31:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic               pend_reg;
    logic signed [31:0] sx, sy;
    logic               acc;

    // sign extend from the configured coordinate width
    assign sx  = 32'(signed'(coord_x[CWE-1:0]));
    assign sy  = 32'(signed'(coord_y[CWE-1:0]));
    assign full = pend_reg | busy;
    assign acc  = push & ~full;
    assign start = pend_reg & ~busy;

    // vertex stores
    always_ff @(posedge clk)
    begin
        if (acc && kind == psat_pkg::KIND_VERT_ONE && cnt_one_reg < CNT_W'(MAX_VERTS))
        begin
            vx1_mem[cnt_one_reg[IDX_W-1:0]] <= sx;
            vy1_mem[cnt_one_reg[IDX_W-1:0]] <= sy;
        end
        if (acc && kind == psat_pkg::KIND_VERT_TWO && cnt_two_reg < CNT_W'(MAX_VERTS))
        begin
            vx2_mem[cnt_two_reg[IDX_W-1:0]] <= sx;
            vy2_mem[cnt_two_reg[IDX_W-1:0]] <= sy;
        end
    end

    // read port for the back part, one vertex of each body
    assign v1x = vx1_mem[rd_idx];
    assign v1y = vy1_mem[rd_idx];
    assign v2x = vx2_mem[rd_idx];
    assign v2y = vy2_mem[rd_idx];

    // counts, positions and the pending test flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_one_reg <= '0;
            cnt_two_reg <= '0;
            p1x_reg <= '0; p1y_reg <= '0; p2x_reg <= '0; p2y_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                pend_reg <= 1'b0;
                cnt_one_reg <= '0;
                cnt_two_reg <= '0;
            end
            if (acc)
            begin
                case (kind)
                    psat_pkg::KIND_VERT_ONE:
                        cnt_one_reg <= (cnt_one_reg < CNT_W'(MAX_VERTS)) ?
                            cnt_one_reg + 1'b1 : CNT_W'(MAX_VERTS + 1);
                    psat_pkg::KIND_VERT_TWO:
                        cnt_two_reg <= (cnt_two_reg < CNT_W'(MAX_VERTS)) ?
                            cnt_two_reg + 1'b1 : CNT_W'(MAX_VERTS + 1);
                    psat_pkg::KIND_POS_ONE:
                    begin
                        p1x_reg <= sx; p1y_reg <= sy;
                    end
                    default:
                    begin
                        p2x_reg <= sx; p2y_reg <= sy;
                    end
                endcase
                pend_reg <= last;
            end
        end
    end

    assign cnt_one = cnt_one_reg;
    assign cnt_two = cnt_two_reg;
    assign pos_dx  = 33'(p2x_reg) - 33'(p1x_reg);
    assign pos_dy  = 33'(p2y_reg) - 33'(p1y_reg);
endmodule
`default_nettype wire

// File: src/psat_back.sv
// psat_back: sequencer that walks edges, normalizes axes and projects both bodies
// depends on psat_pkg
`default_nettype none
module psat_back #(
    parameter int MAX_VERTS = psat_pkg::MAX_VERTS_DEF,
    parameter int CNT_W     = $clog2(MAX_VERTS + 2),
    parameter int IDX_W     = $clog2(MAX_VERTS)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire  [CNT_W-1:0]        cnt_one,
    input  wire  [CNT_W-1:0]        cnt_two,
    input  wire  signed [32:0]      pos_dx,
    input  wire  signed [32:0]      pos_dy,
    output logic [IDX_W-1:0]        rd_idx,
    input  wire  signed [31:0]      v1x,
    input  wire  signed [31:0]      v1y,
    input  wire  signed [31:0]      v2x,
    input  wire  signed [31:0]      v2y,
    output logic                    res_valid,
    output psat_pkg::result_t       res,
    input  wire                     res_ready
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EA    = 4'd1;   // read edge start vertex
    localparam logic [3:0] S_EB    = 4'd2;   // read edge end vertex
    localparam logic [3:0] S_SHR   = 4'd3;   // scale magnitudes below 2^31
    localparam logic [3:0] S_SQ    = 4'd4;   // squares
    localparam logic [3:0] S_SQRT  = 4'd5;   // bitwise root
    localparam logic [3:0] S_DIV   = 4'd6;   // restoring divide of both parts
    localparam logic [3:0] S_PROJ  = 4'd7;   // projection walk
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_ORI   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          st_reg;
    logic                body_reg;       // edge source body
    logic [IDX_W-1:0]    ei_reg;
    logic [IDX_W-1:0]    pi_reg;
    logic                pb_reg;         // projection body
    logic [CNT_W-1:0]    n1_reg, n2_reg; // vertex counts of the running test
    logic signed [32:0]  ax0_reg, ay0_reg;
    logic signed [32:0]  ax_reg, ay_reg;
    logic [32:0]         mx_reg, my_reg;
    logic [63:0]         sq_reg, rem_reg, root_reg;
    logic [5:0]          k_reg;
    logic [31:0]         len_reg;
    logic [45:0]         nqx_reg, nqy_reg;
    logic [46:0]         rx_reg, ry_reg;
    logic [14:0]         qx_reg, qy_reg;
    logic signed [15:0]  nx_reg, ny_reg;
    logic signed [49:0]  lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic                have_reg;
    logic signed [50:0]  best_reg;
    logic signed [15:0]  bx_reg, by_reg;
    logic                sep_reg;
    logic signed [48:0]  px_reg, py_reg;
    logic                bad_reg;
    psat_pkg::result_t   res_reg;
    logic                rv_reg;
    logic                proj_live_reg;
    logic                fold_reg, fold_b_reg, fold_first_reg;

    logic [CNT_W-1:0]    ncur;
    logic [IDX_W-1:0]    enext;
    logic signed [31:0]  sxv, syv, pxv, pyv;
    logic signed [49:0]  dot;
    logic [63:0]         trial, bitv;
    logic [46:0]         rxs, rys;
    logic signed [50:0]  d1, d2, dmin;
    logic [50:0]         rnd;

    assign ncur  = body_reg ? n2_reg : n1_reg;
    assign enext = (CNT_W'(ei_reg) + 1'b1 == ncur) ? '0 : ei_reg + 1'b1;
    assign sxv   = body_reg ? v2x : v1x;
    assign syv   = body_reg ? v2y : v1y;
    assign pxv   = pb_reg ? v2x : v1x;
    assign pyv   = pb_reg ? v2y : v1y;

    always_comb
    begin
        case (st_reg)
            S_EA:    rd_idx = ei_reg;
            S_EB:    rd_idx = enext;
            S_PROJ:  rd_idx = pi_reg;
            default: rd_idx = pi_reg;
        endcase
    end

    // dot product of the registered partial products
    assign dot   = 50'(px_reg) + 50'(py_reg);
    assign bitv  = 64'd1 << {k_reg, 1'b0};
    assign trial = root_reg + bitv;
    assign rxs   = {rx_reg[45:0], nqx_reg[45]};
    assign rys   = {ry_reg[45:0], nqy_reg[45]};
    assign d1    = 51'(hi2_reg) - 51'(lo1_reg);
    assign d2    = 51'(hi1_reg) - 51'(lo2_reg);
    assign dmin  = (d2 < d1) ? d2 : d1;
    assign rnd   = 51'(best_reg) + 51'(1 << (psat_pkg::UNIT_SHIFT - 1));

    // a waiting result holds only the final state, not new loads
    assign busy      = st_reg != S_IDLE;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rv_reg <= 1'b0;
            proj_live_reg <= 1'b0;
        end
        else
        begin
            if (rv_reg && res_ready)
                rv_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        bad_reg  <= cnt_one < CNT_W'(3) || cnt_one > CNT_W'(MAX_VERTS) ||
                                    cnt_two < CNT_W'(3) || cnt_two > CNT_W'(MAX_VERTS);
                        n1_reg   <= cnt_one;
                        n2_reg   <= cnt_two;
                        body_reg <= 1'b0;
                        ei_reg   <= '0;
                        have_reg <= 1'b0;
                        sep_reg  <= 1'b0;
                        st_reg   <= (cnt_one < CNT_W'(3) || cnt_one > CNT_W'(MAX_VERTS) ||
                                     cnt_two < CNT_W'(3) || cnt_two > CNT_W'(MAX_VERTS)) ?
                                    S_OUT : S_EA;
                    end
                end
                S_EA:
                begin
                    ax0_reg <= 33'(syv);
                    ay0_reg <= -33'(sxv);
                    st_reg  <= S_EB;
                end
                S_EB:
                begin
                    // axis = (-ey, ex)
                    ax_reg <= ax0_reg - 33'(syv);
                    ay_reg <= 33'(sxv) + ay0_reg;
                    mx_reg <= (ax0_reg - 33'(syv) < 0) ? 33'(-(ax0_reg - 33'(syv))) :
                                                          33'(ax0_reg - 33'(syv));
                    my_reg <= (33'(sxv) + ay0_reg < 0) ? 33'(-(33'(sxv) + ay0_reg)) :
                                                          33'(33'(sxv) + ay0_reg);
                    st_reg <= S_SHR;
                end
                S_SHR:
                begin
                    if (mx_reg == '0 && my_reg == '0)
                        st_reg <= S_CMP;
                    else if (mx_reg[32:31] != 2'b00 || my_reg[32:31] != 2'b00)
                    begin
                        mx_reg <= mx_reg >> 1;
                        my_reg <= my_reg >> 1;
                    end
                    else
                    begin
                        sq_reg <= 64'(mx_reg[30:0]) * 64'(mx_reg[30:0]);
                        st_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    rem_reg  <= sq_reg + 64'(my_reg[30:0]) * 64'(my_reg[30:0]);
                    root_reg <= '0;
                    k_reg    <= 6'd31;
                    st_reg   <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bitv;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    k_reg <= k_reg - 1'b1;
                    if (k_reg == '0)
                    begin
                        len_reg <= (rem_reg >= trial) ? 32'((root_reg >> 1) + bitv) :
                                                        32'(root_reg >> 1);
                        st_reg <= S_DIV;
                        k_reg  <= 6'd45;
                        rx_reg <= '0;
                        ry_reg <= '0;
                        qx_reg <= '0;
                        qy_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    // first cycle loads dividends, then 46 restoring steps
                    if (k_reg == 6'd45 && rx_reg == '0 && ry_reg == '0 &&
                        qx_reg == '0 && qy_reg == '0 && !proj_live_reg)
                    begin
                        nqx_reg <= ({15'd0, mx_reg[30:0]} << psat_pkg::UNIT_SHIFT) +
                                   46'(len_reg >> 1);
                        nqy_reg <= ({15'd0, my_reg[30:0]} << psat_pkg::UNIT_SHIFT) +
                                   46'(len_reg >> 1);
                        proj_live_reg <= 1'b1;
                    end
                    else
                    begin
                        nqx_reg <= nqx_reg << 1;
                        nqy_reg <= nqy_reg << 1;
                        if (rxs >= 47'(len_reg))
                        begin
                            rx_reg <= rxs - 47'(len_reg);
                            qx_reg <= {qx_reg[13:0], 1'b1};
                        end
                        else
                        begin
                            rx_reg <= rxs;
                            qx_reg <= {qx_reg[13:0], 1'b0};
                        end
                        if (rys >= 47'(len_reg))
                        begin
                            ry_reg <= rys - 47'(len_reg);
                            qy_reg <= {qy_reg[13:0], 1'b1};
                        end
                        else
                        begin
                            ry_reg <= rys;
                            qy_reg <= {qy_reg[13:0], 1'b0};
                        end
                        k_reg <= k_reg - 1'b1;
                        if (k_reg == '0)
                        begin
                            proj_live_reg <= 1'b0;
                            nx_reg <= ax_reg < 0 ?
                                -16'({rxs >= 47'(len_reg) ? {qx_reg, 1'b1} : {qx_reg, 1'b0}}) :
                                16'({rxs >= 47'(len_reg) ? {qx_reg, 1'b1} : {qx_reg, 1'b0}});
                            ny_reg <= ay_reg < 0 ?
                                -16'({rys >= 47'(len_reg) ? {qy_reg, 1'b1} : {qy_reg, 1'b0}}) :
                                16'({rys >= 47'(len_reg) ? {qy_reg, 1'b1} : {qy_reg, 1'b0}});
                            pi_reg <= '0;
                            pb_reg <= 1'b0;
                            st_reg <= S_PROJ;
                        end
                    end
                end
                S_PROJ:
                begin
                    // products of the current vertex, folded into min and max next cycle
                    px_reg <= 49'(pxv) * 49'(nx_reg);
                    py_reg <= 49'(pyv) * 49'(ny_reg);
                    proj_live_reg <= 1'b1;
                    // advance vertex walk
                    if (CNT_W'(pi_reg) + 1'b1 == (pb_reg ? n2_reg : n1_reg))
                    begin
                        pi_reg <= '0;
                        if (pb_reg)
                            st_reg <= S_CMP;
                        pb_reg <= ~pb_reg;
                    end
                    else
                        pi_reg <= pi_reg + 1'b1;
                end
                S_CMP:
                begin
                    // wait while the last product is still being folded
                    if (!fold_reg)
                    begin
                        if (mx_reg == '0 && my_reg == '0) ;
                        else
                        begin
                            if (lo1_reg >= hi2_reg || lo2_reg >= hi1_reg)
                                sep_reg <= 1'b1;
                            else if (!have_reg || dmin < best_reg)
                            begin
                                have_reg <= 1'b1;
                                best_reg <= dmin;
                                bx_reg   <= nx_reg;
                                by_reg   <= ny_reg;
                            end
                        end
                        proj_live_reg <= 1'b0;
                        if ((mx_reg != '0 || my_reg != '0) &&
                            (lo1_reg >= hi2_reg || lo2_reg >= hi1_reg))
                            st_reg <= S_OUT;
                        else if (CNT_W'(ei_reg) + 1'b1 == ncur)
                        begin
                            ei_reg <= '0;
                            if (body_reg)
                                st_reg <= S_ORI;
                            else
                            begin
                                body_reg <= 1'b1;
                                st_reg <= S_EA;
                            end
                        end
                        else
                        begin
                            ei_reg <= ei_reg + 1'b1;
                            st_reg <= S_EA;
                        end
                    end
                end
                S_ORI:
                begin
                    px_reg <= 49'(pos_dx) * 49'(bx_reg);
                    py_reg <= 49'(pos_dy) * 49'(by_reg);
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rv_reg || res_ready)
                    begin
                        rv_reg <= 1'b1;
                        res_reg.status <= bad_reg ? psat_pkg::STATUS_BAD_COUNT :
                                                    psat_pkg::STATUS_OK;
                        if (!bad_reg && !sep_reg && have_reg)
                        begin
                            res_reg.hit <= 1'b1;
                            res_reg.normal_x <= (dot < 0) ? -bx_reg : bx_reg;
                            res_reg.normal_y <= (dot < 0) ? -by_reg : by_reg;
                            res_reg.depth <= (rnd[50:psat_pkg::UNIT_SHIFT] > 37'h7FFFFFFF) ?
                                31'h7FFFFFFF : rnd[psat_pkg::UNIT_SHIFT +: 31];
                        end
                        else
                        begin
                            res_reg.hit <= 1'b0;
                            res_reg.normal_x <= '0;
                            res_reg.normal_y <= '0;
                            res_reg.depth <= '0;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // min and max tracking fed from the product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= 1'b0;
            fold_b_reg <= 1'b0;
            fold_first_reg <= 1'b0;
        end
        else
        begin
            fold_reg       <= st_reg == S_PROJ;
            fold_b_reg     <= pb_reg;
            fold_first_reg <= pi_reg == '0;
            if (fold_reg)
            begin
                if (!fold_b_reg)
                begin
                    if (fold_first_reg || dot < lo1_reg) lo1_reg <= dot;
                    if (fold_first_reg || dot > hi1_reg) hi1_reg <= dot;
                end
                else
                begin
                    if (fold_first_reg || dot < lo2_reg) lo2_reg <= dot;
                    if (fold_first_reg || dot > hi2_reg) hi2_reg <= dot;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == S_IDLE) else $error("start while busy");
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && res_reg.hit |-> res_reg.normal_x <= 16'sd16384 &&
        res_reg.normal_x >= -16'sd16384) else $error("normal out of range");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !res_reg.hit |-> res_reg.depth == '0) else $error("miss with depth");
    a_bad_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && res_reg.status |-> !res_reg.hit) else $error("bad count with hit");
`endif
endmodule
`default_nettype wire

// File: verif/testbench.sv
// testbench: self-checking bench for polygon_sat_collision_top (2d separating-axis test)
// depends on psat_pkg and the rtl under src; holds its own fixed-point predictor
`default_nettype none
module testbench;

    localparam int NVERT      = psat_pkg::MAX_VERTS_DEF;
    localparam int ITEM_GOAL  = 1750;
    localparam int STALL_MAX  = 40000;
    localparam int HOLD_LEN   = 6000;
    localparam longint UNIT_Q = 64'sd16384;
    localparam longint DEPTH_SAT = 64'sh7FFFFFFF;

    // one load beat plus pacing controls
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        int          mode;
        bit          drain;
        bit          hold;
    } load_beat_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic        last;
    logic        empty;
    logic        pop;
    logic        hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0] depth;
    logic        status;

    load_beat_t  load_queue[$];
    psat_pkg::result_t contact_queue[$];
    int          errors = 0;
    int          gen_count = 0;
    int          cur_mode = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    // predictor state
    longint      poly_one[NVERT][2];
    longint      poly_two[NVERT][2];
    int          cnt_one = 0;
    int          cnt_two = 0;
    longint      pos_one[2] = '{0, 0};
    longint      pos_two[2] = '{0, 0};

    polygon_sat_collision_top DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .coord_x(coord_x), .coord_y(coord_y), .last(last), .empty(empty),
        .pop(pop), .hit(hit), .normal_x(normal_x), .normal_y(normal_y),
        .depth(depth), .status(status)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (8) #4 clk = ~clk;
        rst_n = 1'b1;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit normal in q2.14; false for a zero vector
    function automatic bit unit_axis(input longint ax, input longint ay,
                                     output longint nx, output longint ny);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned len;
        longint unsigned qx;
        longint unsigned qy;
        nx = 0;
        ny = 0;
        mx = ax < 0 ? -ax : ax;
        my = ay < 0 ? -ay : ay;
        if (mx == 0 && my == 0)
            return 1'b0;
        while ((mx >> 31) != 0 || (my >> 31) != 0)
        begin
            mx >>= 1;
            my >>= 1;
        end
        len = int_sqrt(mx * mx + my * my);
        qx = (mx * 16384 + len / 2) / len;
        qy = (my * 16384 + len / 2) / len;
        nx = ax < 0 ? -longint'(qx) : longint'(qx);
        ny = ay < 0 ? -longint'(qy) : longint'(qy);
        return 1'b1;
    endfunction

    function automatic void span(input bit second, input longint nx, input longint ny,
                                 output longint lo, output longint hi);
        longint p;
        int n;
        lo = 0;
        hi = 0;
        n = second ? cnt_two : cnt_one;
        for (int i = 0; i < n && i < NVERT; i++)
        begin
            p = second ? poly_two[i][0] * nx + poly_two[i][1] * ny
                       : poly_one[i][0] * nx + poly_one[i][1] * ny;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    // walks the edge normals of one body; returns 0 when an axis separates
    function automatic bit edges_overlap(input bit second, inout bit have,
                                         inout longint best, inout longint bx,
                                         inout longint by);
        int n;
        int j;
        longint ex;
        longint ey;
        longint nx;
        longint ny;
        longint lo1;
        longint hi1;
        longint lo2;
        longint hi2;
        longint d;
        n = second ? cnt_two : cnt_one;
        for (int i = 0; i < n && i < NVERT; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            ex = second ? poly_two[j][0] - poly_two[i][0] : poly_one[j][0] - poly_one[i][0];
            ey = second ? poly_two[j][1] - poly_two[i][1] : poly_one[j][1] - poly_one[i][1];
            if (!unit_axis(-ey, ex, nx, ny))
                continue;
            span(1'b0, nx, ny, lo1, hi1);
            span(1'b1, nx, ny, lo2, hi2);
            if (lo1 >= hi2 || lo2 >= hi1)
                return 1'b0;
            d = hi2 - lo1;
            if (hi1 - lo2 < d) d = hi1 - lo2;
            if (!have || d < best)
            begin
                have = 1'b1;
                best = d;
                bx = nx;
                by = ny;
            end
        end
        return 1'b1;
    endfunction

    // applies one accepted beat and queues a contact when the beat has last set
    function automatic void predict_contact(input load_beat_t b);
        longint x;
        longint y;
        bit have;
        longint best;
        longint bx;
        longint by;
        longint dr;
        psat_pkg::result_t r;
        x = longint'(signed'(b.x));
        y = longint'(signed'(b.y));
        have = 1'b0;
        best = 0;
        bx = 0;
        by = 0;
        case (b.kind)
            psat_pkg::KIND_VERT_ONE:
                if (cnt_one < NVERT)
                begin
                    poly_one[cnt_one][0] = x;
                    poly_one[cnt_one][1] = y;
                    cnt_one++;
                end
                else cnt_one = NVERT + 1;
            psat_pkg::KIND_VERT_TWO:
                if (cnt_two < NVERT)
                begin
                    poly_two[cnt_two][0] = x;
                    poly_two[cnt_two][1] = y;
                    cnt_two++;
                end
                else cnt_two = NVERT + 1;
            psat_pkg::KIND_POS_ONE:
            begin
                pos_one[0] = x;
                pos_one[1] = y;
            end
            default:
            begin
                pos_two[0] = x;
                pos_two[1] = y;
            end
        endcase
        if (!b.last)
            return;
        r = '0;
        r.status = psat_pkg::STATUS_OK;
        if (cnt_one < 3 || cnt_one > NVERT || cnt_two < 3 || cnt_two > NVERT)
            r.status = psat_pkg::STATUS_BAD_COUNT;
        else if (edges_overlap(1'b0, have, best, bx, by) &&
                 edges_overlap(1'b1, have, best, bx, by) && have)
        begin
            r.hit = 1'b1;
            if ((pos_two[0] - pos_one[0]) * bx + (pos_two[1] - pos_one[1]) * by < 0)
            begin
                bx = -bx;
                by = -by;
            end
            dr = (best + UNIT_Q / 2) >>> psat_pkg::UNIT_SHIFT;
            if (dr > DEPTH_SAT) dr = DEPTH_SAT;
            r.normal_x = bx[15:0];
            r.normal_y = by[15:0];
            r.depth = dr[30:0];
        end
        cnt_one = 0;
        cnt_two = 0;
        contact_queue.push_back(r);
    endfunction

    function automatic int idle_pct(input int mode, input bit sender);
        case (mode)
            1: return sender ? 50 : 0;
            2: return sender ? 0 : 50;
            3: return 24;
            default: return 0;
        endcase
    endfunction

    // driver: offers queued beats, honoring drain pauses
    always @(posedge clk or negedge rst_n)
    begin
        bit go;
        if (!rst_n)
        begin
            push <= 1'b0;
            kind <= psat_pkg::KIND_VERT_ONE;
            coord_x <= '0;
            coord_y <= '0;
            last <= 1'b0;
        end
        else
        begin
            go = 1'b0;
            if (push && !full)
            begin
                predict_contact(load_queue[0]);
                cur_mode = load_queue[0].mode;
                if (load_queue[0].hold) hold_request = 1;
                void'(load_queue.pop_front());
            end
            if (push && full)
                go = 1'b1;
            else if (load_queue.size() != 0)
            begin
                if (load_queue[0].drain && contact_queue.size() != 0)
                    go = 1'b0;
                else
                begin
                    load_queue[0].drain = 1'b0;
                    go = $urandom_range(99) >= idle_pct(load_queue[0].mode, 1'b1);
                end
            end
            push <= go;
            if (load_queue.size() != 0)
            begin
                kind <= load_queue[0].kind;
                coord_x <= load_queue[0].x;
                coord_y <= load_queue[0].y;
                last <= load_queue[0].last;
            end
        end
    end

    // monitor: compares each popped beat with the oldest predicted contact
    always @(posedge clk or negedge rst_n)
    begin
        psat_pkg::result_t e;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (contact_queue.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b status=%0b", $time, hit, status);
                    errors++;
                end
                else
                begin
                    e = contact_queue.pop_front();
                    if (e.hit !== hit || e.normal_x !== normal_x || e.normal_y !== normal_y ||
                        e.depth !== depth || e.status !== status)
                    begin
                        $display("%0t: mismatch expected hit=%0b nx=%0d ny=%0d depth=%0d st=%0b",
                                 $time, e.hit, e.normal_x, e.normal_y, e.depth, e.status);
                        $display("%0t:          actual   hit=%0b nx=%0d ny=%0d depth=%0d st=%0b",
                                 $time, hit, normal_x, normal_y, depth, status);
                        errors++;
                    end
                end
            end
            if (hold_request != 0)
            begin
                hold_request = 0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= $urandom_range(99) >= idle_pct(cur_mode, 1'b0);
        end
    end

    // watchdog on cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (rst_n && ((push && !full) || (pop && !empty)))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_beat(input logic [1:0] k, input longint x, input longint y,
                            input logic lst);
        load_beat_t b;
        b.kind = k;
        b.x = x[31:0];
        b.y = y[31:0];
        b.last = lst;
        b.mode = (gen_count / 120) % 4;
        b.drain = (gen_count % 300 == 150);
        b.hold = (gen_count == 500 || gen_count == 1300);
        load_queue.push_back(b);
        gen_count++;
    endtask

    // loads a pair of bodies with interleaved beats, last on the final beat
    task automatic add_pair(input longint v1[$], input longint v2[$],
                            input longint p1x, input longint p1y,
                            input longint p2x, input longint p2y);
        logic [1:0] ks[$];
        longint xs[$];
        longint ys[$];
        int i1;
        int i2;
        int total;
        i1 = 0;
        i2 = 0;
        ks.push_back(psat_pkg::KIND_POS_ONE); xs.push_back(p1x); ys.push_back(p1y);
        ks.push_back(psat_pkg::KIND_POS_TWO); xs.push_back(p2x); ys.push_back(p2y);
        while (i1 < v1.size() || i2 < v2.size())
        begin
            if (i2 >= v2.size() || (i1 < v1.size() && $urandom_range(1)))
            begin
                ks.push_back(psat_pkg::KIND_VERT_ONE);
                xs.push_back(v1[i1]); ys.push_back(v1[i1+1]);
                i1 += 2;
            end
            else
            begin
                ks.push_back(psat_pkg::KIND_VERT_TWO);
                xs.push_back(v2[i2]); ys.push_back(v2[i2+1]);
                i2 += 2;
            end
        end
        if ($urandom_range(1))
        begin
            ks.push_back(ks[0]); xs.push_back(xs[0]); ys.push_back(ys[0]);
            ks.delete(0); xs.delete(0); ys.delete(0);
        end
        total = ks.size();
        for (int i = 0; i < total; i++)
            add_beat(ks[i], xs[i], ys[i], i == total - 1);
    endtask

    // polygon with vertices on a circle at random angles, mirrored or not
    function automatic void make_poly(input int n, input longint cx, input longint cy,
                                      input longint rad, output longint v[$]);
        real a;
        real step;
        bit cw;
        v.delete();
        step = 6.283185307 / n;
        cw = $urandom_range(1) != 0;
        for (int i = 0; i < n; i++)
        begin
            a = step * i + step * 0.3 * ($urandom_range(1000) / 1000.0) +
                ($urandom_range(6283) / 1000.0);
            if (cw) a = -a + 100.0;
            v.push_back(cx + longint'(rad * $cos(a)));
            v.push_back(cy + longint'(rad * $sin(a)));
        end
    endfunction

    function automatic longint rnd32();
        return longint'(signed'($urandom));
    endfunction

    // stimulus and end of run
    initial
    begin
        longint a[$];
        longint b[$];
        longint c;
        longint r;
        int n1;
        int n2;
        int pick;
        // overlapping squares, separated, touching
        a = '{0, 0, 65536, 0, 65536, 65536, 0, 65536};
        b = '{32768, 16384, 98304, 16384, 98304, 81920, 32768, 81920};
        add_pair(a, b, 32768, 32768, 65536, 49152);
        add_pair(a, b, 65536, 49152, 32768, 32768);
        b = '{65536, 0, 131072, 0, 131072, 65536, 65536, 65536};
        add_pair(a, b, 0, 0, 65536, 0);
        b = '{200000, 0, 300000, 0, 250000, 90000};
        add_pair(a, b, 0, 0, 1, 1);
        // bad counts: two vertices, nine vertices
        add_pair('{0, 0, 9, 9}, b, 0, 0, 0, 0);
        make_poly(9, 0, 0, 100000, a);
        add_pair(a, b, 0, 0, 0, 0);
        // repeated vertex, then all vertices equal
        add_pair('{0, 0, 0, 0, 65536, 0, 0, 65536}, '{10, 10, 40000, 10, 10, 40000},
                 0, 0, 5, 5);
        add_pair('{7, 7, 7, 7, 7, 7}, '{7, 7, 7, 7, 7, 7}, 0, 0, 0, 0);
        // coordinate extremes and saturating depth
        add_pair('{-2147483648, -2147483648, 2147483647, -2147483648, 2147483647, 2147483647,
                   -2147483648, 2147483647},
                 '{-2147483648, -2147483648, 2147483647, -2147483648, 0, 2147483647},
                 -2147483648, 2147483647, 2147483647, -2147483648);
        // random part
        while (gen_count < ITEM_GOAL)
        begin
            pick = $urandom_range(9);
            if (pick < 7)
            begin
                r = (pick < 5) ? $urandom_range(4000000, 1000) : $urandom_range(500000000, 1000);
                c = (pick < 5) ? $urandom_range(20000000) : $urandom_range(1000000000);
                n1 = $urandom_range(NVERT, 3);
                n2 = $urandom_range(NVERT, 3);
                make_poly(n1, c, c / 2, r, a);
                make_poly(n2, c + $urandom_range(3 * r) - r, c / 2 + $urandom_range(2 * r) - r,
                          $urandom_range(r, r / 4 + 1), b);
                add_pair(a, b, a[0], a[1], b[0] + $urandom_range(2000) - 1000, b[1]);
            end
            else if (pick == 7)
            begin
                n1 = $urandom_range(10);
                n2 = $urandom_range(10);
                make_poly(n1 == 0 ? 1 : n1, 0, 0, 300000, a);
                make_poly(n2 == 0 ? 1 : n2, 100000, 0, 300000, b);
                if (n1 == 0) a.delete();
                if (n2 == 0) b.delete();
                add_pair(a, b, 0, 0, rnd32(), rnd32());
            end
            else
            begin
                for (int i = 0; i < 6; i++)
                    add_beat(2'($urandom_range(3)), rnd32(), rnd32(), $urandom_range(3) == 0);
                add_beat(2'($urandom_range(3)), rnd32(), rnd32(), 1'b1);
            end
        end
        @(posedge rst_n);
        while (load_queue.size() != 0 || contact_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// File: polygon_sat_collision_top.f
src/psat_pkg.sv
src/psat_front.sv
src/psat_back.sv
src/polygon_sat_collision_top.sv
verif/testbench.sv
